// ----- hw/rtl/srl_pkg.sv -----
// Shared types and constants for the slew rate limiter core.
// Holds the value widths, the register index codes and the configuration struct.
// No dependencies.
package srl_pkg;

	localparam int VALUE_WIDTH = 16;
	localparam int STEP_WIDTH  = VALUE_WIDTH - 1;
	localparam int EXT_WIDTH   = VALUE_WIDTH + 2;
	localparam int ADDR_WIDTH  = 5;
	localparam int DATA_WIDTH  = 32;

	typedef enum logic [2:0] {
		REG_RISE_STEP       = 3'd0,
		REG_FALL_STEP       = 3'd1,
		REG_FALL_ENABLE     = 3'd2,
		REG_REVERSIBLE_MODE = 3'd3,
		REG_LIMIT_ENABLE    = 3'd4,
		REG_LIMIT_VALUE     = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [STEP_WIDTH-1:0]         rise_step;
		logic [STEP_WIDTH-1:0]         fall_step;
		logic                          fall_enable;
		logic                          reversible_mode;
		logic                          limit_enable;
		logic signed [VALUE_WIDTH-1:0] limit_value;
	} cfg_t;

endpackage

// ----- hw/rtl/srl_step.sv -----
// Next-output logic of the slew rate limiter: one step or preload per request.
// Depends on srl_pkg for widths and the configuration struct.
module srl_step
	import srl_pkg::*;
(
	input  cfg_t                          cfg,
	input  logic                          op,
	input  logic signed [VALUE_WIDTH-1:0] cur,
	input  logic signed [VALUE_WIDTH-1:0] tgt,
	output logic signed [VALUE_WIDTH-1:0] nxt
);

	logic signed [EXT_WIDTH-1:0] cur_e, tgt_e, r_e, f_e, up_e, dn_e;
	logic signed [EXT_WIDTH-1:0] hi_e, lo_e, app_e, hi_r, lo_r, ro_e, lim_e, res_e;
	logic                        tgt_pos, tgt_neg;

	always_comb begin
		cur_e   = EXT_WIDTH'(cur);
		tgt_e   = EXT_WIDTH'(tgt);
		lim_e   = EXT_WIDTH'(cfg.limit_value);
		r_e     = $signed({{(EXT_WIDTH-STEP_WIDTH){1'b0}}, cfg.rise_step});
		f_e     = $signed({{(EXT_WIDTH-STEP_WIDTH){1'b0}}, cfg.fall_step});
		tgt_neg = tgt[VALUE_WIDTH-1];
		tgt_pos = !tgt[VALUE_WIDTH-1] && (tgt != '0);

		if (!cfg.reversible_mode || tgt_pos) begin
			up_e = r_e;
			dn_e = f_e;
		end else if (tgt_neg) begin
			up_e = f_e;
			dn_e = r_e;
		end else begin
			up_e = f_e;
			dn_e = f_e;
		end

		hi_e = cur_e + up_e;
		lo_e = cur_e - dn_e;
		if (tgt_e > hi_e) begin
			app_e = hi_e;
		end else if (tgt_e < lo_e) begin
			app_e = lo_e;
		end else begin
			app_e = tgt_e;
		end
		if (cfg.limit_enable) begin
			if (!lim_e[EXT_WIDTH-1] && (lim_e != '0) && (app_e > lim_e)) begin
				app_e = lim_e;
			end
			if (lim_e[EXT_WIDTH-1] && (app_e < lim_e)) begin
				app_e = lim_e;
			end
		end

		hi_r = cur_e + r_e;
		lo_r = cur_e - r_e;
		if (tgt_pos) begin
			ro_e = (tgt_e > hi_r) ? hi_r : tgt_e;
		end else if (tgt_neg) begin
			ro_e = (tgt_e < lo_r) ? lo_r : tgt_e;
		end else begin
			ro_e = cur_e;
		end

		if (op) begin
			res_e = tgt_e;
		end else if (cfg.fall_enable) begin
			res_e = app_e;
		end else begin
			res_e = ro_e;
		end
		nxt = res_e[VALUE_WIDTH-1:0];
	end

endmodule

// ----- hw/rtl/slew_rate_limiter_core.sv -----
// Channel   Handshake               Payload
// request   req_valid / req_ready   op, value
// result    drive_valid / drive_ready  drive_out
// config    APB write/read          paddr, pwdata, prdata
//
// One request per cycle while drive_ready keeps up: a request enters an input register
// and its result is computed into the output register, which is also the state.
// drive_valid rises as the output register takes the result. While a result waits,
// the input register takes one more request, and then req_ready stays low.
// Reset clears the output, the configuration registers and all valid flags to zero.
// Top level of the slew rate limiter; depends on srl_pkg and srl_step.
module slew_rate_limiter_core
	import srl_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ADDR_WIDTH-1:0]         paddr,
	input  logic [DATA_WIDTH-1:0]         pwdata,
	output logic [DATA_WIDTH-1:0]         prdata,
	output logic                          pready,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic                          op,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          drive_valid,
	input  logic                          drive_ready,
	output logic signed [VALUE_WIDTH-1:0] drive_out
);

	cfg_t                          cfg_q;
	reg_idx_t                      reg_idx;
	logic                          cfg_wr;
	logic                          valid_s1, op_s1;
	logic signed [VALUE_WIDTH-1:0] value_s1;
	logic                          drive_valid_q;
	logic signed [VALUE_WIDTH-1:0] drive_q, next_drive;
	logic                          advance;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_WIDTH-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_RISE_STEP:       cfg_q.rise_step <= pwdata[STEP_WIDTH-1:0];
				REG_FALL_STEP:       cfg_q.fall_step <= pwdata[STEP_WIDTH-1:0];
				REG_FALL_ENABLE:     cfg_q.fall_enable <= pwdata[0];
				REG_REVERSIBLE_MODE: cfg_q.reversible_mode <= pwdata[0];
				REG_LIMIT_ENABLE:    cfg_q.limit_enable <= pwdata[0];
				REG_LIMIT_VALUE:     cfg_q.limit_value <= pwdata[VALUE_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_RISE_STEP:       prdata = DATA_WIDTH'(cfg_q.rise_step);
			REG_FALL_STEP:       prdata = DATA_WIDTH'(cfg_q.fall_step);
			REG_FALL_ENABLE:     prdata = DATA_WIDTH'(cfg_q.fall_enable);
			REG_REVERSIBLE_MODE: prdata = DATA_WIDTH'(cfg_q.reversible_mode);
			REG_LIMIT_ENABLE:    prdata = DATA_WIDTH'(cfg_q.limit_enable);
			REG_LIMIT_VALUE:     prdata = DATA_WIDTH'(cfg_q.limit_value);
			default:             prdata = '0;
		endcase
	end

	assign advance   = valid_s1 && (!drive_valid_q || drive_ready);
	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			op_s1    <= op;
			value_s1 <= value;
		end
	end

	srl_step u_step (
		.cfg (cfg_q),
		.op  (op_s1),
		.cur (drive_q),
		.tgt (value_s1),
		.nxt (next_drive)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_valid_q <= 1'b0;
			drive_q       <= '0;
		end else begin
			if (advance) begin
				drive_valid_q <= 1'b1;
				drive_q       <= next_drive;
			end else if (drive_ready) begin
				drive_valid_q <= 1'b0;
			end
		end
	end

	assign drive_valid = drive_valid_q;
	assign drive_out   = drive_q;

`ifndef SYNTHESIS
	a_preload: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 |=> drive_q == $past(value_s1))
		else $error("preload did not take the request value");

	a_rise_only_hold: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !op_s1 && !cfg_q.fall_enable && (value_s1 == '0)
		|=> drive_q == $past(drive_q))
		else $error("rise-only mode moved the output on a zero target");

	a_clamp_high: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !op_s1 && cfg_q.fall_enable && cfg_q.limit_enable
		&& (cfg_q.limit_value > 0) |=> drive_q <= $past(cfg_q.limit_value))
		else $error("output passed the upper clamp");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(drive_valid_q) |-> $past(valid_s1))
		else $error("result appeared without a request in the input register");
`endif

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for slew_rate_limiter_core: drives requests and APB writes,
// predicts each drive_out from a local copy of the limiter state and checks it in order.
// Depends on srl_pkg and the slew_rate_limiter_core RTL.
`timescale 1ns / 1ps

module testbench;
	import srl_pkg::*;

	localparam logic OP_STEP    = 1'b0;
	localparam logic OP_PRELOAD = 1'b1;
	localparam logic [ADDR_WIDTH-1:0] UNMAPPED_ADDR = {3'd6, 2'b00};
	localparam int LONG_HOLD   = 300;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic                          op;
		logic signed [VALUE_WIDTH-1:0] value;
	} drive_req_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [ADDR_WIDTH-1:0]         paddr = '0;
	logic [DATA_WIDTH-1:0]         pwdata = '0;
	logic [DATA_WIDTH-1:0]         prdata;
	logic                          pready;
	logic                          req_valid = 1'b0;
	logic                          req_ready;
	logic                          op = 1'b0;
	logic signed [VALUE_WIDTH-1:0] value = '0;
	logic                          drive_valid;
	logic                          drive_ready = 1'b0;
	logic signed [VALUE_WIDTH-1:0] drive_out;

	drive_req_t                    drive_requests[$];
	logic signed [VALUE_WIDTH-1:0] expected_drive[$];
	cfg_t                          drive_cfg = '0;
	logic signed [VALUE_WIDTH-1:0] drive_state = '0;
	logic signed [VALUE_WIDTH-1:0] want_drive;
	drive_req_t                    next_req;
	logic                          offering;
	int                            pushed_count = 0;
	int                            accepted_count = 0;
	int                            mismatches = 0;
	int                            cycle_count = 0;
	int                            send_idle_pct = 0;
	int                            recv_stall_pct = 0;
	logic                          hold_start = 1'b0;
	int                            hold_left = 0;

	slew_rate_limiter_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.op          (op),
		.value       (value),
		.drive_valid (drive_valid),
		.drive_ready (drive_ready),
		.drive_out   (drive_out)
	);

	always #4 clk = ~clk;

	function automatic int move_toward(input int cur, input int tgt, input int up, input int down);
		if (tgt > cur + up)
			return cur + up;
		if (tgt < cur - down)
			return cur - down;
		return tgt;
	endfunction

	function automatic logic signed [VALUE_WIDTH-1:0] slew_next(input drive_req_t req);
		int cur;
		int tgt;
		int up;
		int dn;
		int lim;
		cur = drive_state;
		tgt = req.value;
		up  = drive_cfg.rise_step;
		dn  = drive_cfg.fall_step;
		lim = drive_cfg.limit_value;
		if (req.op == OP_PRELOAD) begin
			cur = tgt;
		end else if (drive_cfg.fall_enable) begin
			if (!drive_cfg.reversible_mode || tgt > 0)
				cur = move_toward(cur, tgt, up, dn);
			else if (tgt < 0)
				cur = move_toward(cur, tgt, dn, up);
			else
				cur = move_toward(cur, tgt, dn, dn);
			if (drive_cfg.limit_enable) begin
				if (lim > 0 && cur > lim)
					cur = lim;
				if (lim < 0 && cur < lim)
					cur = lim;
			end
		end else if (tgt > 0) begin
			cur = (tgt > cur + up) ? cur + up : tgt;
		end else if (tgt < 0) begin
			cur = (tgt < cur - up) ? cur - up : tgt;
		end
		return cur[VALUE_WIDTH-1:0];
	endfunction

	// Request driver: holds the payload until accepted and predicts on acceptance.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			op        <= OP_STEP;
			value     <= '0;
		end else begin
			offering = req_valid;
			if (req_valid && req_ready) begin
				drive_state = slew_next('{op: op, value: value});
				expected_drive.push_back(drive_state);
				accepted_count++;
				offering = 1'b0;
			end
			if (!offering && drive_requests.size() != 0 &&
					$urandom_range(99) >= send_idle_pct) begin
				next_req = drive_requests.pop_front();
				op       <= next_req.op;
				value    <= next_req.value;
				offering = 1'b1;
			end
			req_valid <= offering;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			drive_ready <= 1'b0;
		end else begin
			if (drive_valid && drive_ready) begin
				if (expected_drive.size() == 0) begin
					$display("%0t: drive_out %0d arrived with no request outstanding",
						$time, drive_out);
					mismatches++;
				end else begin
					want_drive = expected_drive.pop_front();
					if (drive_out !== want_drive) begin
						$display("%0t: drive_out expected %0d actual %0d",
							$time, want_drive, drive_out);
						mismatches++;
					end
				end
			end
			drive_ready <= hold_left == 0 && !hold_start &&
				$urandom_range(99) >= recv_stall_pct;
		end
	end

	always @(posedge clk) begin
		if (hold_start)
			hold_left <= LONG_HOLD;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic push_request(input logic req_op, input logic signed [VALUE_WIDTH-1:0] req_value);
		drive_requests.push_back('{op: req_op, value: req_value});
		pushed_count++;
	endtask

	task automatic drain();
		while (accepted_count != pushed_count || expected_drive.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [ADDR_WIDTH-1:0] addr, input logic [DATA_WIDTH-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (reg_idx_t'(addr[ADDR_WIDTH-1:2]))
			REG_RISE_STEP:       drive_cfg.rise_step       = data[STEP_WIDTH-1:0];
			REG_FALL_STEP:       drive_cfg.fall_step       = data[STEP_WIDTH-1:0];
			REG_FALL_ENABLE:     drive_cfg.fall_enable     = data[0];
			REG_REVERSIBLE_MODE: drive_cfg.reversible_mode = data[0];
			REG_LIMIT_ENABLE:    drive_cfg.limit_enable    = data[0];
			REG_LIMIT_VALUE:     drive_cfg.limit_value     = data[VALUE_WIDTH-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_cfg(input logic [STEP_WIDTH-1:0] rise, input logic [STEP_WIDTH-1:0] fall,
			input logic fen, input logic rev, input logic len,
			input logic signed [VALUE_WIDTH-1:0] lim);
		logic [DATA_WIDTH-1:0] noise;
		noise = $urandom();
		cfg_write({REG_RISE_STEP, 2'b00}, {noise[DATA_WIDTH-1:STEP_WIDTH], rise});
		cfg_write({REG_FALL_STEP, 2'b00}, {noise[DATA_WIDTH-1:STEP_WIDTH], fall});
		cfg_write({REG_FALL_ENABLE, 2'b00}, {noise[DATA_WIDTH-1:1], fen});
		cfg_write({REG_REVERSIBLE_MODE, 2'b00}, {noise[DATA_WIDTH-1:1], rev});
		cfg_write({REG_LIMIT_ENABLE, 2'b00}, {noise[DATA_WIDTH-1:1], len});
		cfg_write({REG_LIMIT_VALUE, 2'b00}, {noise[DATA_WIDTH-1:VALUE_WIDTH], lim});
	endtask

	function automatic logic [STEP_WIDTH-1:0] pick_step();
		case ($urandom_range(5))
			0: return '0;
			1: return STEP_WIDTH'(1);
			2: return '1;
			3: return STEP_WIDTH'($urandom_range(1, 64));
			4: return STEP_WIDTH'($urandom_range(64, 2048));
			default: return STEP_WIDTH'($urandom_range(0, 32767));
		endcase
	endfunction

	function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
		int v;
		case ($urandom_range(9))
			0, 1: v = 0;
			2: v = 32767;
			3: v = -32768;
			4, 5: v = int'($urandom_range(0, 4000)) - 2000;
			default: v = $urandom();
		endcase
		return v[VALUE_WIDTH-1:0];
	endfunction

	// Targets mostly repeat for a few requests so the output can settle on them.
	task automatic gen_requests(input int count);
		logic signed [VALUE_WIDTH-1:0] target;
		int made;
		int reps;
		made = 0;
		while (made < count) begin
			target = pick_value();
			if ($urandom_range(99) < 10) begin
				push_request(OP_PRELOAD, target);
				made++;
			end else begin
				reps = $urandom_range(1, 6);
				for (int i = 0; i < reps && made < count; i++) begin
					push_request(OP_STEP, target);
					made++;
				end
			end
		end
	endtask

	initial begin
		logic signed [VALUE_WIDTH-1:0] lim;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_request(OP_STEP, 16'sh7fff);
		push_request(OP_PRELOAD, 16'sh7fff);
		push_request(OP_STEP, 16'sh8000);
		push_request(OP_STEP, 16'sh0000);
		push_request(OP_PRELOAD, 16'sh8000);
		drain();

		apply_cfg('1, '1, 1'b1, 1'b0, 1'b0, 16'sd0);
		push_request(OP_STEP, 16'sh7fff);
		push_request(OP_STEP, 16'sh7fff);
		push_request(OP_STEP, 16'sh8000);
		push_request(OP_STEP, 16'sh8000);
		drain();

		apply_cfg(15'd256, 15'd64, 1'b1, 1'b0, 1'b1, 16'sd1000);
		push_request(OP_PRELOAD, 16'sd3000);
		push_request(OP_STEP, 16'sd3000);
		push_request(OP_STEP, -16'sd1000);
		push_request(OP_STEP, 16'sd2000);
		drain();

		apply_cfg(15'd256, 15'd64, 1'b1, 1'b1, 1'b1, -16'sd1000);
		push_request(OP_PRELOAD, 16'sd0);
		push_request(OP_STEP, -16'sd5000);
		push_request(OP_STEP, 16'sd5000);
		push_request(OP_STEP, 16'sd0);
		push_request(OP_PRELOAD, -16'sd3000);
		push_request(OP_STEP, -16'sd3000);
		push_request(OP_STEP, 16'sd0);
		drain();

		apply_cfg(15'd100, 15'd50, 1'b0, 1'b1, 1'b1, 16'sd500);
		push_request(OP_PRELOAD, 16'sd1000);
		push_request(OP_STEP, 16'sd0);
		push_request(OP_STEP, -16'sd200);
		push_request(OP_STEP, 16'sd2000);
		drain();

		for (int p = 0; p < 12; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
				default: begin send_idle_pct = 28; recv_stall_pct = 28; end
			endcase
			case ($urandom_range(4))
				0: lim = '0;
				1: lim = 16'sh7fff;
				2: lim = 16'sh8000;
				3: lim = VALUE_WIDTH'(int'($urandom_range(0, 4000)) - 2000);
				default: lim = VALUE_WIDTH'($urandom());
			endcase
			if (p == 0)
				apply_cfg('1, '0, 1'b1, 1'b1, 1'b1, 16'sh8000);
			else if (p == 1)
				apply_cfg('0, '1, 1'b1, 1'b0, 1'b1, 16'sh7fff);
			else
				apply_cfg(pick_step(), pick_step(), $urandom_range(3) != 0,
					1'($urandom_range(1)), 1'($urandom_range(1)), lim);
			if (p == 3)
				cfg_write(UNMAPPED_ADDR, $urandom());
			if (p == 4) begin
				@(posedge clk);
				hold_start <= 1'b1;
				@(posedge clk);
				hold_start <= 1'b0;
			end
			gen_requests(62);
			drain();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_drive.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
